>>> src/acg_pkg.sv
// Shared constants, types and the modulo-65521 fold for the Adler-32 group checksum.
// No dependencies; used by every module under src.
package acg_pkg;

	// Adler-32 modulus and group geometry
	localparam int unsigned ADLER_MOD        = 65521;
	localparam int          LANES            = 4;
	localparam int          LANE_BYTES       = 8;
	localparam int          LANE_W           = LANE_BYTES * 8;
	localparam int          MAX_BYTES        = LANES * LANE_BYTES;
	localparam int          GROUP_BYTES_DEF  = 32;
	localparam int          COUNT_W          = 6;
	localparam int          SEED_W           = 32;

	// Widths of partial results
	localparam int          LANE_BSUM_W      = 11;  // 8 bytes, at most 2040
	localparam int          LANE_ISUM_W      = 16;  // sum of pos * byte, pos up to 31
	localparam int          BSUM_W           = 13;  // 32 bytes, at most 8160
	localparam int          ISUM_W           = 18;
	localparam int          WSUM_W           = COUNT_W + BSUM_W;
	localparam int          RED_W            = 24;  // input width of mod_fold

	localparam logic [16:0] MOD17            = 17'(ADLER_MOD);

	// Per-lane partial sums
	typedef struct packed {
		logic [LANE_BSUM_W-1:0] bsum;
		logic [LANE_ISUM_W-1:0] isum;
	} lane_sum_t;

	// Per-item control carried down the pipe
	typedef struct packed {
		logic [COUNT_W-1:0] n;
		logic               first;
		logic [SEED_W-1:0]  seed;
		logic               last;
	} item_ctrl_t;

	// What the accumulator needs for one item
	typedef struct packed {
		logic [BSUM_W-1:0]  bsum;
		logic [15:0]        wsum;     // weighted sum, already reduced
		logic [15:0]        seed_lo;  // reduced
		logic [15:0]        seed_hi;  // reduced
		logic [COUNT_W-1:0] n;
		logic               first;
		logic               last;
	} acc_item_t;

	// x mod 65521 for x below 2^24: 2^16 = 15 (mod 65521), then one subtract
	function automatic logic [15:0] mod_fold(input logic [RED_W-1:0] x);
		logic [16:0] f;
		f = 17'(x[15:0]) + 17'(x[RED_W-1:16]) * 17'd15;
		if (f >= MOD17) begin
			f = f - MOD17;
		end
		return f[15:0];
	endfunction

endpackage

>>> src/adler32_group_checksum.sv
// Top level of the Adler-32 group checksum: lanes, merge, weighting and accumulator.
// Depends on acg_pkg, acg_lane, acg_merge and acg_accum.
//
//   channel  dir  signals                        contents
//   s_*      in   tvalid tready tdata tuser tlast 32 stream bytes, count, seed, first, last
//   m_*      out  tvalid tready tdata tlast       running checksum, final flag
//
// One item per cycle sustained while m_tready accepts results; the result is registered
// in each stage below and leaves from the accumulator register.
// Stage 1 lane sums, 2 merge, 3 count weighting, 4 mod reduction and seed
// reduction, 5 the sum update loop in the accumulator, which sets the rate.
// Reset sets the sums to low 1, high 0 and empties the pipe.
// Each stage moves on when it is empty or the next one moves, so bubbles close up
// and input is taken while a result waits at the output.
module adler32_group_checksum #(
	parameter int GROUP_BYTES = acg_pkg::GROUP_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] bytes 0..7, [127:64] bytes 8..15, [191:128] bytes 16..23,
	// [255:192] bytes 24..31, [261:256] byte_count, [293:262] seed, [295:294] zero
	input  logic [295:0] s_tdata,
	input  logic         s_tuser,   // [0] first_group
	input  logic         s_tlast,   // last_group
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // [31:0] checksum
	output logic         m_tlast    // final_res
);

	localparam int LIMIT = (GROUP_BYTES < acg_pkg::MAX_BYTES) ? GROUP_BYTES
		: acg_pkg::MAX_BYTES;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4, acc_ready;

	logic [acg_pkg::COUNT_W-1:0] n_raw;
	logic [acg_pkg::COUNT_W-1:0] n_clamp;
	acg_pkg::lane_sum_t          lane_sums [acg_pkg::LANES];
	acg_pkg::lane_sum_t          lane_s1   [acg_pkg::LANES];
	acg_pkg::item_ctrl_t         ctrl_in, ctrl_s1, ctrl_s2, ctrl_s3;
	logic [acg_pkg::BSUM_W-1:0]  bsum_m, bsum_s2, bsum_s3;
	logic [acg_pkg::ISUM_W-1:0]  isum_m, isum_s2;
	logic [acg_pkg::WSUM_W-1:0]  wsum_s3;
	acg_pkg::acc_item_t          acc_s4;

	// Stall chain, from the accumulator back
	assign en4      = !v_s4 || acc_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	// Count clamp and input control
	assign n_raw   = s_tdata[261:256];
	assign n_clamp = (n_raw > acg_pkg::COUNT_W'(LIMIT)) ? acg_pkg::COUNT_W'(LIMIT) : n_raw;
	always_comb begin
		ctrl_in.n     = n_clamp;
		ctrl_in.first = s_tuser;
		ctrl_in.seed  = s_tdata[293:262];
		ctrl_in.last  = s_tlast;
	end

	// Byte lanes
	for (genvar l = 0; l < acg_pkg::LANES; l++) begin : g_lane
		acg_lane #(.LANE_IDX(l)) u_lane (
			.bytes(s_tdata[l*acg_pkg::LANE_W +: acg_pkg::LANE_W]),
			.n    (n_clamp),
			.sums (lane_sums[l])
		);
	end

	acg_merge u_merge (
		.lane_sums(lane_s1),
		.bsum     (bsum_m),
		.isum     (isum_m)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en1) begin
			lane_s1 <= lane_sums;
			ctrl_s1 <= ctrl_in;
		end
		if (en2) begin
			bsum_s2 <= bsum_m;
			isum_s2 <= isum_m;
			ctrl_s2 <= ctrl_s1;
		end
		// W = n*B - sum(pos*d) = sum((n - pos)*d)
		if (en3) begin
			bsum_s3 <= bsum_s2;
			wsum_s3 <= acg_pkg::WSUM_W'(acg_pkg::WSUM_W'(ctrl_s2.n) *
				acg_pkg::WSUM_W'(bsum_s2)) - acg_pkg::WSUM_W'(isum_s2);
			ctrl_s3 <= ctrl_s2;
		end
		// Reduce W and the seed halves
		if (en4) begin
			acc_s4.bsum    <= bsum_s3;
			acc_s4.wsum    <= acg_pkg::mod_fold(acg_pkg::RED_W'(wsum_s3));
			acc_s4.seed_lo <= acg_pkg::mod_fold(acg_pkg::RED_W'(ctrl_s3.seed[15:0]));
			acc_s4.seed_hi <= acg_pkg::mod_fold(acg_pkg::RED_W'(ctrl_s3.seed[31:16]));
			acc_s4.n       <= ctrl_s3.n;
			acc_s4.first   <= ctrl_s3.first;
			acc_s4.last    <= ctrl_s3.last;
		end
	end

	acg_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_ready (acc_ready),
		.in_item  (acc_s4),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_sum  (m_tdata),
		.out_last (m_tlast)
	);

endmodule

>>> src/acg_lane.sv
// One byte lane of the checksum: plain and position-weighted sums of its valid bytes.
// Depends on acg_pkg.
module acg_lane #(
	parameter int LANE_IDX = 0
) (
	input  logic [acg_pkg::LANE_W-1:0]  bytes,
	input  logic [acg_pkg::COUNT_W-1:0] n,
	output acg_pkg::lane_sum_t          sums
);

	// Mask bytes at or past the count, then accumulate
	always_comb begin
		logic [acg_pkg::LANE_BSUM_W-1:0] bs;
		logic [acg_pkg::LANE_ISUM_W-1:0] is;
		logic [7:0]                      d;
		logic [acg_pkg::COUNT_W-1:0]     pos;
		bs = '0;
		is = '0;
		for (int j = 0; j < acg_pkg::LANE_BYTES; j++) begin
			pos = acg_pkg::COUNT_W'(LANE_IDX * acg_pkg::LANE_BYTES + j);
			d   = (pos < n) ? bytes[j*8 +: 8] : 8'd0;
			bs  = bs + acg_pkg::LANE_BSUM_W'(d);
			is  = is + acg_pkg::LANE_ISUM_W'(pos) * acg_pkg::LANE_ISUM_W'(d);
		end
		sums.bsum = bs;
		sums.isum = is;
	end

endmodule

>>> src/acg_merge.sv
// Merges the lane sums into the group byte sum and the position-weighted sum.
// Depends on acg_pkg.
module acg_merge (
	input  acg_pkg::lane_sum_t          lane_sums [acg_pkg::LANES],
	output logic [acg_pkg::BSUM_W-1:0]  bsum,
	output logic [acg_pkg::ISUM_W-1:0]  isum
);

	// Four-way adder for each sum
	always_comb begin
		bsum = '0;
		isum = '0;
		for (int l = 0; l < acg_pkg::LANES; l++) begin
			bsum = bsum + acg_pkg::BSUM_W'(lane_sums[l].bsum);
			isum = isum + acg_pkg::ISUM_W'(lane_sums[l].isum);
		end
	end

endmodule

>>> src/acg_accum.sv
// Running Adler-32 sums: seed load, per-item update and the output register.
// Depends on acg_pkg.
module acg_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  acg_pkg::acc_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_sum,
	output logic               out_last
);

	logic        valid_q;
	logic        last_q;
	logic [15:0] low_q;
	logic [15:0] high_q;
	logic [15:0] low_base;
	logic [15:0] high_base;
	logic [15:0] low_nxt;
	logic [15:0] high_nxt;
	logic        take;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Sum update: low += B, high += n*low + W, both mod 65521
	always_comb begin
		low_base  = in_item.first ? in_item.seed_lo : low_q;
		high_base = in_item.first ? in_item.seed_hi : high_q;
		low_nxt   = acg_pkg::mod_fold(acg_pkg::RED_W'(low_base) +
			acg_pkg::RED_W'(in_item.bsum));
		high_nxt  = acg_pkg::mod_fold(acg_pkg::RED_W'(high_base) +
			acg_pkg::RED_W'(in_item.n) * acg_pkg::RED_W'(low_base) +
			acg_pkg::RED_W'(in_item.wsum));
	end

	// State doubles as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			low_q   <= 16'd1;
			high_q  <= 16'd0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				low_q   <= low_nxt;
				high_q  <= high_nxt;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= in_item.last;
		end
	end

	assign out_valid = valid_q;
	assign out_sum   = {high_q, low_q};
	assign out_last  = last_q;

endmodule
